/* src/rbs_pkg.sv */
// shared widths for the ray box slab intersection unit
`timescale 1ns / 1ps
package rbs_pkg;
  localparam int IN_W     = 32;
  localparam int HALF_W   = 30;
  localparam int DIFF_W   = 35;
  localparam int MAG_W    = 34;
  localparam int DEN_W    = 32;
  localparam int DIR_FRAC = 30;
  localparam int NUM_W    = MAG_W + DIR_FRAC;
  localparam int REM_W    = DEN_W + 1;
  localparam int OUT_W    = 32;
  localparam int AXES     = 3;

  typedef struct packed {
    logic            valid;
    logic            miss;
    logic [AXES-1:0] dzero;
  } rbs_meta_t;
endpackage

/* src/rbs_div.sv */
// pipelined restoring divider: saturated (num << 30) / den, one quotient bit per stage
`timescale 1ns / 1ps
module rbs_div
  import rbs_pkg::*;
#(
  parameter int CB = 32
) (
  input  logic                 clk,
  input  logic [MAG_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  input  logic                 neg,
  output logic signed [CB-1:0] quo
);
  localparam int HI_W = NUM_W - CB;
  localparam logic [CB-1:0] LIM_POS = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] LIM_NEG = {1'b1, {(CB-1){1'b0}}};

  logic [NUM_W-1:0] a_full;
  logic [HI_W-1:0]  a_hi;

  logic [REM_W-1:0] r_s   [0:CB];
  logic [CB-1:0]    q_s   [0:CB];
  logic [CB-1:0]    low_s [0:CB];
  logic [DEN_W-1:0] den_s [0:CB];
  logic             neg_s [0:CB];
  logic             sat_s [0:CB];

  logic [CB-1:0] q_lim;
  logic [CB-1:0] q_sel;

  assign a_full = {num, {DIR_FRAC{1'b0}}};
  assign a_hi   = a_full[NUM_W-1:CB];

  always_ff @(posedge clk) begin
    r_s[0]   <= REM_W'(a_hi);
    q_s[0]   <= '0;
    low_s[0] <= a_full[CB-1:0];
    den_s[0] <= den;
    neg_s[0] <= neg;
    sat_s[0] <= (NUM_W'(a_hi) >= NUM_W'(den));
  end

  for (genvar j = 1; j <= CB; j++) begin : g_stage
    logic [REM_W-1:0] t;
    logic             ge;
    assign t  = {r_s[j-1][REM_W-2:0], low_s[j-1][CB-1]};
    assign ge = (t >= {1'b0, den_s[j-1]});
    always_ff @(posedge clk) begin
      r_s[j]   <= ge ? (t - {1'b0, den_s[j-1]}) : t;
      q_s[j]   <= {q_s[j-1][CB-2:0], ge};
      low_s[j] <= {low_s[j-1][CB-2:0], 1'b0};
      den_s[j] <= den_s[j-1];
      neg_s[j] <= neg_s[j-1];
      sat_s[j] <= sat_s[j-1];
    end
  end

  assign q_lim = neg_s[CB] ? LIM_NEG : LIM_POS;
  assign q_sel = (sat_s[CB] || (q_s[CB] > q_lim)) ? q_lim : q_s[CB];

  always_ff @(posedge clk) begin
    quo <= neg_s[CB] ? signed'(-q_sel) : signed'(q_sel);
  end
endmodule

/* src/ray_box_slab_intersect_unit.sv */
// top level of the ray versus axis aligned cube slab intersection unit
`timescale 1ns / 1ps
// one ray and one cube per word: origin, direction, cube center and half size
// a word is taken at each rising edge with start high; busy is always low, so
// a new word may follow every cycle
// each word gives one result word on hit and entry_distance, marked by done
// for exactly one cycle; the receiver cannot stall and need not
// throughput: one word per cycle
// the pipeline runs through six restoring dividers that resolve one quotient bit
// per stage, plus a difference stage, a pre-check stage, a saturation stage,
// a fold stage and the output register
// a miss gives hit low and entry_distance zero
// reset clears the valid bits of every stage and done; words in flight are
// dropped
module ray_box_slab_intersect_unit
  import rbs_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  origin_x,
  input  logic signed [IN_W-1:0]  origin_y,
  input  logic signed [IN_W-1:0]  origin_z,
  input  logic signed [IN_W-1:0]  dir_x,
  input  logic signed [IN_W-1:0]  dir_y,
  input  logic signed [IN_W-1:0]  dir_z,
  input  logic signed [IN_W-1:0]  center_x,
  input  logic signed [IN_W-1:0]  center_y,
  input  logic signed [IN_W-1:0]  center_z,
  input  logic [HALF_W-1:0]       half_size,
  output logic                    done,
  output logic                    hit,
  output logic signed [OUT_W-1:0] entry_distance
);
  localparam int CB = COORD_BITS;
  localparam int DLY = CB + 2;
  localparam int WIDE = 64;
  localparam logic signed [CB-1:0] D_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] D_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [WIDE-1:0] O_MAX = WIDE'(64'sh7FFF_FFFF);
  localparam logic signed [WIDE-1:0] O_MIN = -WIDE'(64'sh8000_0000);

  logic signed [IN_W-1:0] org [AXES];
  logic signed [IN_W-1:0] dir [AXES];
  logic signed [IN_W-1:0] ctr [AXES];

  assign org = '{origin_x, origin_y, origin_z};
  assign dir = '{dir_x, dir_y, dir_z};
  assign ctr = '{center_x, center_y, center_z};

  logic signed [DIFF_W-1:0] dlo [AXES];
  logic signed [DIFF_W-1:0] dhi [AXES];
  logic signed [IN_W-1:0]   dreg [AXES];
  logic                     a_valid;

  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      dlo[i]  <= DIFF_W'(ctr[i]) - DIFF_W'(half_size) - DIFF_W'(org[i]);
      dhi[i]  <= DIFF_W'(ctr[i]) + DIFF_W'(half_size) - DIFF_W'(org[i]);
      dreg[i] <= dir[i];
    end
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start;
    end
  end

  rbs_meta_t a_meta;
  always_comb begin
    a_meta.valid = a_valid;
    a_meta.miss  = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      a_meta.dzero[i] = (dreg[i] == '0);
      if (a_meta.dzero[i] && (dlo[i] > 0 || dhi[i] < 0)) begin
        a_meta.miss = 1'b1;
      end
    end
  end

  rbs_meta_t dl [0:DLY-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DLY; k++) begin
        dl[k] <= '0;
      end
    end else begin
      dl[0] <= a_meta;
      for (int k = 1; k < DLY; k++) begin
        dl[k] <= dl[k-1];
      end
    end
  end

  logic signed [CB-1:0] tq_lo [AXES];
  logic signed [CB-1:0] tq_hi [AXES];

  for (genvar i = 0; i < AXES; i++) begin : g_axis
    logic [DEN_W-1:0] den_mag;
    logic [MAG_W-1:0] lo_mag;
    logic [MAG_W-1:0] hi_mag;
    assign den_mag = dreg[i][IN_W-1] ? DEN_W'(-(IN_W+1)'(dreg[i])) : DEN_W'(dreg[i]);
    assign lo_mag  = dlo[i][DIFF_W-1] ? MAG_W'(-dlo[i]) : MAG_W'(dlo[i]);
    assign hi_mag  = dhi[i][DIFF_W-1] ? MAG_W'(-dhi[i]) : MAG_W'(dhi[i]);

    rbs_div #(.CB(CB)) u_div_lo (
      .clk (clk),
      .num (lo_mag),
      .den (den_mag),
      .neg (dlo[i][DIFF_W-1] ^ dreg[i][IN_W-1]),
      .quo (tq_lo[i])
    );
    rbs_div #(.CB(CB)) u_div_hi (
      .clk (clk),
      .num (hi_mag),
      .den (den_mag),
      .neg (dhi[i][DIFF_W-1] ^ dreg[i][IN_W-1]),
      .quo (tq_hi[i])
    );
  end

  logic signed [CB-1:0] near_next;
  logic signed [CB-1:0] far_next;
  logic signed [CB-1:0] t1;
  logic signed [CB-1:0] t2;

  always_comb begin
    near_next = D_MIN;
    far_next  = D_MAX;
    t1 = '0;
    t2 = '0;
    for (int i = 0; i < AXES; i++) begin
      t1 = (tq_lo[i] > tq_hi[i]) ? tq_hi[i] : tq_lo[i];
      t2 = (tq_lo[i] > tq_hi[i]) ? tq_lo[i] : tq_hi[i];
      if (!dl[DLY-1].dzero[i]) begin
        if (t1 > near_next) begin
          near_next = t1;
        end
        if (t2 < far_next) begin
          far_next = t2;
        end
      end
    end
  end

  logic                 f_valid;
  logic                 f_miss;
  logic signed [CB-1:0] f_near;
  logic signed [CB-1:0] f_far;

  always_ff @(posedge clk) begin
    f_near <= near_next;
    f_far  <= far_next;
    f_miss <= dl[DLY-1].miss;
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= dl[DLY-1].valid;
    end
  end

  logic                   miss_all;
  logic signed [WIDE-1:0] near_w;
  logic signed [OUT_W-1:0] near_sat;

  assign miss_all = f_miss || (f_near > f_far) || (f_far < 0);
  assign near_w   = WIDE'(f_near);
  assign near_sat = (near_w > O_MAX) ? OUT_W'(O_MAX) :
                    (near_w < O_MIN) ? OUT_W'(O_MIN) : OUT_W'(near_w);

  always_ff @(posedge clk) begin
    hit            <= !miss_all;
    entry_distance <= miss_all ? '0 : near_sat;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_valid;
    end
  end

  assign busy = 1'b0;

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> entry_distance == '0)
    else $error("miss word with nonzero distance");

  a_fold_to_done: assert property (@(posedge clk) disable iff (rst)
    f_valid |=> done)
    else $error("folded word lost before output");

  a_start_flows: assert property (@(posedge clk) disable iff (rst)
    start |=> a_valid && dl[0].valid == 1'b0 || a_valid)
    else $error("accepted word not captured");
endmodule
